/* hdl/crc_pkg.sv */
// ----------------------------------------------------------------------------
// crc_pkg: shared types and constants for the curl repetition counter
// Field widths, phase codes, register indexes and fixed thresholds.
// ----------------------------------------------------------------------------
package crc_pkg;

  // field widths
  localparam int ANGLE_W  = 9;
  localparam int TILT_W   = 9;
  localparam int ACCEL_W  = 16;
  localparam int COUNT_W  = 10;
  localparam int REPS_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // fixed thresholds of the hold phase
  localparam logic [COUNT_W-1:0] HOLD_SAMPLES = COUNT_W'(100);
  localparam logic [TILT_W-1:0]  HOLD_TILT    = TILT_W'(30);

  // running minimum restart value, counter ceiling and tilt ceiling
  localparam logic [TILT_W-1:0]  MIN_RESET = TILT_W'(90);
  localparam logic [COUNT_W-1:0] CNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [TILT_W-1:0]  TILT_MAX  = {TILT_W{1'b1}};

  // register reset values
  localparam logic [TILT_W-1:0]  UP_RESET     = TILT_W'(60);
  localparam logic [TILT_W-1:0]  DOWN_RESET   = TILT_W'(20);
  localparam logic signed [ACCEL_W-1:0] ACCEL_RESET = -ACCEL_W'(200);
  localparam logic [COUNT_W-1:0] PIVOT_RESET  = COUNT_W'(20);
  localparam logic [REPS_W-1:0]  TARGET_RESET = REPS_W'(10);

  // phase codes as seen on the result
  typedef enum logic [1:0] {
    PHASE_CAL   = 2'd0,
    PHASE_HOLD  = 2'd1,
    PHASE_COUNT = 2'd2
  } phase_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UP_THRESHOLD      = 3'd0,
    CFG_DOWN_THRESHOLD    = 3'd1,
    CFG_PIVOT_ACCEL_LIMIT = 3'd2,
    CFG_PIVOT_SAMPLES     = 3'd3,
    CFG_TARGET_REPS       = 3'd4
  } cfg_idx_t;

endpackage

/* hdl/crc_tilt.sv */
// ----------------------------------------------------------------------------
// crc_tilt: tilt relative to the stored level
// Forms |(|pitch| + |roll|) - level|, saturated to the tilt width.
// ----------------------------------------------------------------------------
module crc_tilt (
  input  logic signed [crc_pkg::ANGLE_W-1:0] pitch,
  input  logic signed [crc_pkg::ANGLE_W-1:0] roll,
  input  logic        [crc_pkg::TILT_W-1:0]  level,
  output logic        [crc_pkg::TILT_W-1:0]  tilt
);

  localparam int SUM_W  = crc_pkg::ANGLE_W + 1;
  localparam int DIFF_W = SUM_W + 1;

  logic [crc_pkg::ANGLE_W-1:0] pitch_mag;
  logic [crc_pkg::ANGLE_W-1:0] roll_mag;
  logic [SUM_W-1:0]            mag_sum;
  logic signed [DIFF_W-1:0]    diff;
  logic [DIFF_W-1:0]           diff_mag;

  // magnitudes; the most negative angle maps to its unsigned magnitude
  assign pitch_mag = pitch[crc_pkg::ANGLE_W-1] ? (~pitch + 1'b1) : pitch;
  assign roll_mag  = roll[crc_pkg::ANGLE_W-1]  ? (~roll + 1'b1)  : roll;

  assign mag_sum = SUM_W'(pitch_mag) + SUM_W'(roll_mag);
  assign diff    = $signed(DIFF_W'(mag_sum)) - $signed(DIFF_W'(level));
  assign diff_mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;

  // saturate to the tilt range
  assign tilt = (diff_mag > DIFF_W'(crc_pkg::TILT_MAX)) ? crc_pkg::TILT_MAX
                                                         : diff_mag[crc_pkg::TILT_W-1:0];

endmodule

/* hdl/curl_repetition_counter.sv */
// ----------------------------------------------------------------------------
// curl_repetition_counter: counts arm curls from motion sensor samples
// Calibration, hold-still and rep counting over a valid/stall sample stream.
// ----------------------------------------------------------------------------
// Every accepted sample beat yields exactly one result beat. A sample is
// captured in an input register and, once the result register is free, the
// tilt and all phase, counter and flag updates are computed in one pass and
// land in the result register together with the new state, so one sample
// is taken every cycle while results are taken without stalls. The result
// register decouples the two sides: the block keeps taking samples while a
// result waits, until both its registers are full. Configuration is to be
// written by the user through cfg_write/cfg_index/cfg_data only while idle;
// the block itself does not enforce this.
module curl_repetition_counter (
  input  logic clk,
  input  logic rst,
  // configuration write port
  input  logic                                 cfg_write,
  input  logic [crc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [crc_pkg::CFG_DATA_W-1:0]       cfg_data,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [crc_pkg::ANGLE_W-1:0]   pitch_angle,
  input  logic signed [crc_pkg::ANGLE_W-1:0]   roll_angle,
  input  logic signed [crc_pkg::ACCEL_W-1:0]   vertical_accel,
  input  logic                                 button,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           phase,
  output logic [crc_pkg::REPS_W-1:0]           rep_count,
  output logic [crc_pkg::REPS_W-1:0]           best_reps,
  output logic                                 pivot_seen,
  output logic                                 set_done,
  output logic [crc_pkg::TILT_W-1:0]           tilt
);

  function automatic logic [crc_pkg::COUNT_W-1:0] sat_inc(
    input logic [crc_pkg::COUNT_W-1:0] c
  );
    sat_inc = (c == crc_pkg::CNT_MAX) ? c : c + 1'b1;
  endfunction

  // configuration registers
  logic [crc_pkg::TILT_W-1:0]         up_threshold;
  logic [crc_pkg::TILT_W-1:0]         down_threshold;
  logic signed [crc_pkg::ACCEL_W-1:0] pivot_accel_limit;
  logic [crc_pkg::COUNT_W-1:0]        pivot_samples;
  logic [crc_pkg::REPS_W-1:0]         target_reps;

  // input register
  logic                               in_full;
  logic signed [crc_pkg::ANGLE_W-1:0] pitch_q;
  logic signed [crc_pkg::ANGLE_W-1:0] roll_q;
  logic signed [crc_pkg::ACCEL_W-1:0] accel_q;
  logic                               button_q;

  // tracking state
  logic [crc_pkg::TILT_W-1:0]  level_offset, level_offset_next;
  logic                        calibrated, calibrated_next;
  logic                        set_active, set_active_next;
  logic [crc_pkg::REPS_W-1:0]  reps_done, reps_done_next;
  logic [crc_pkg::COUNT_W-1:0] sample_counter, sample_counter_next;
  logic [crc_pkg::TILT_W-1:0]  tilt_min, tilt_min_next;
  logic [crc_pkg::TILT_W-1:0]  tilt_max, tilt_max_next;
  logic                        pivot_flag, pivot_flag_next;
  logic                        rising_flag, rising_flag_next;
  logic [crc_pkg::REPS_W-1:0]  record_reps, record_reps_next;
  logic                        done_next;

  logic                        advance;
  logic [crc_pkg::TILT_W-1:0]  tilt_cur;
  logic [crc_pkg::COUNT_W-1:0] cnt_inc;
  logic [crc_pkg::TILT_W-1:0]  max_upd;
  logic [crc_pkg::TILT_W-1:0]  min_base;
  logic [crc_pkg::REPS_W-1:0]  reps_inc;
  logic                        pivot_fire;
  crc_pkg::phase_t             phase_next;

  // handshake: a sample moves on when the result register is free
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      up_threshold      <= crc_pkg::UP_RESET;
      down_threshold    <= crc_pkg::DOWN_RESET;
      pivot_accel_limit <= crc_pkg::ACCEL_RESET;
      pivot_samples     <= crc_pkg::PIVOT_RESET;
      target_reps       <= crc_pkg::TARGET_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        crc_pkg::CFG_UP_THRESHOLD:      up_threshold      <= cfg_data[crc_pkg::TILT_W-1:0];
        crc_pkg::CFG_DOWN_THRESHOLD:    down_threshold    <= cfg_data[crc_pkg::TILT_W-1:0];
        crc_pkg::CFG_PIVOT_ACCEL_LIMIT: pivot_accel_limit <= $signed(cfg_data);
        crc_pkg::CFG_PIVOT_SAMPLES:     pivot_samples     <= cfg_data[crc_pkg::COUNT_W-1:0];
        crc_pkg::CFG_TARGET_REPS:       target_reps       <= cfg_data[crc_pkg::REPS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      pitch_q  <= pitch_angle;
      roll_q   <= roll_angle;
      accel_q  <= vertical_accel;
      button_q <= button;
    end
  end

  crc_tilt u_tilt (
    .pitch (pitch_q),
    .roll  (roll_q),
    .level (level_offset),
    .tilt  (tilt_cur)
  );

  // shared helper terms
  assign cnt_inc  = sat_inc(sample_counter);
  assign max_upd  = (tilt_cur > tilt_max) ? tilt_cur : tilt_max;
  assign reps_inc = reps_done + 1'b1;
  assign pivot_fire = set_active && (reps_done < target_reps) && !button_q && !pivot_flag
                      && (accel_q < pivot_accel_limit) && (cnt_inc >= pivot_samples)
                      && (max_upd > up_threshold);
  assign min_base = pivot_fire ? crc_pkg::MIN_RESET : tilt_min;

  // state update for one sample
  always_comb begin
    level_offset_next   = level_offset;
    calibrated_next     = calibrated;
    set_active_next     = set_active;
    reps_done_next      = reps_done;
    sample_counter_next = sample_counter;
    tilt_min_next       = tilt_min;
    tilt_max_next       = tilt_max;
    pivot_flag_next     = pivot_flag;
    rising_flag_next    = rising_flag;
    record_reps_next    = record_reps;
    done_next           = 1'b0;
    if (!set_active) begin
      if (!calibrated) begin
        // calibration: on a button press, this sample's tilt becomes the level
        if (button_q) begin
          level_offset_next = tilt_cur;
          calibrated_next   = 1'b1;
        end
      end else begin
        // hold still before a set
        sample_counter_next = (tilt_cur <= crc_pkg::HOLD_TILT) ? cnt_inc : '0;
        if (sample_counter_next >= crc_pkg::HOLD_SAMPLES) begin
          set_active_next     = 1'b1;
          reps_done_next      = '0;
          sample_counter_next = '0;
        end
      end
    end else if (reps_done < target_reps && !button_q) begin
      tilt_max_next = max_upd;
      if (!pivot_flag) begin
        // pivot detection on sustained low acceleration
        if (accel_q < pivot_accel_limit) begin
          sample_counter_next = cnt_inc;
          if (pivot_fire) begin
            pivot_flag_next     = 1'b1;
            rising_flag_next    = 1'b1;
            sample_counter_next = '0;
          end
        end else begin
          sample_counter_next = '0;
        end
      end else if (tilt_cur < down_threshold && rising_flag && tilt_cur > tilt_min) begin
        // arm lowered and rising again: one curl
        reps_done_next   = reps_inc;
        rising_flag_next = 1'b0;
        pivot_flag_next  = 1'b0;
        tilt_max_next    = '0;
        if (reps_inc > record_reps) begin
          record_reps_next = reps_inc;
        end
      end
      tilt_min_next = (tilt_cur < min_base) ? tilt_cur : min_base;
    end else if (reps_done >= target_reps) begin
      set_active_next = 1'b0;
      done_next       = 1'b1;
    end
  end

  // phase after the sample
  always_comb begin
    if (set_active_next) begin
      phase_next = crc_pkg::PHASE_COUNT;
    end else if (calibrated_next) begin
      phase_next = crc_pkg::PHASE_HOLD;
    end else begin
      phase_next = crc_pkg::PHASE_CAL;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level_offset   <= '0;
      calibrated     <= 1'b0;
      set_active     <= 1'b0;
      reps_done      <= '0;
      sample_counter <= '0;
      tilt_min       <= crc_pkg::MIN_RESET;
      tilt_max       <= '0;
      pivot_flag     <= 1'b0;
      rising_flag    <= 1'b0;
      record_reps    <= '0;
    end else if (advance) begin
      level_offset   <= level_offset_next;
      calibrated     <= calibrated_next;
      set_active     <= set_active_next;
      reps_done      <= reps_done_next;
      sample_counter <= sample_counter_next;
      tilt_min       <= tilt_min_next;
      tilt_max       <= tilt_max_next;
      pivot_flag     <= pivot_flag_next;
      rising_flag    <= rising_flag_next;
      record_reps    <= record_reps_next;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      phase      <= phase_next;
      rep_count  <= reps_done_next;
      best_reps  <= record_reps_next;
      pivot_seen <= pivot_flag_next;
      set_done   <= done_next;
      tilt       <= tilt_cur;
    end
  end

  // a set only runs on a stored level
  a_active_calibrated: assert property (@(posedge clk) disable iff (rst)
    set_active |-> calibrated)
    else $error("set active without calibration");

  // the record never trails the current count
  a_record_covers: assert property (@(posedge clk) disable iff (rst)
    record_reps >= reps_done)
    else $error("best rep count below current count");

  // a new set starts from zero reps and a clear counter
  a_set_start: assert property (@(posedge clk) disable iff (rst)
    $rose(set_active) |-> (reps_done == '0) && (sample_counter == '0))
    else $error("set started with stale counters");

  // the ending beat reports the hold phase
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && set_done) |-> (phase == crc_pkg::PHASE_HOLD))
    else $error("set done beat with wrong phase");

endmodule
